// ----- sv/dq_pkg.sv -----
// Shared types and codes for the double-ended queue.
// Holds request, status, cell operation and state machine types.
// No dependencies; every other file refers to it by scoped names.
package dq_pkg;

    localparam int unsigned VALUE_W = 32;

    typedef logic signed [VALUE_W-1:0] t_value;

    typedef enum logic [2:0] {
        REQ_PUSH_BACK  = 3'd0,
        REQ_PUSH_FRONT = 3'd1,
        REQ_POP_BACK   = 3'd2,
        REQ_POP_FRONT  = 3'd3,
        REQ_LIST_FWD   = 3'd4,
        REQ_LIST_REV   = 3'd5
    } t_req;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } t_status;

    // What every cell of the row does in a cycle.
    typedef enum logic [1:0] {
        CELL_HOLD  = 2'd0,
        CELL_SHL   = 2'd1,
        CELL_SHR   = 2'd2,
        CELL_WRITE = 2'd3
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        t_value   inject;
    } t_cell_ctrl;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_LIST = 1'b1
    } t_state;

endpackage

// ----- sv/dq_cell.sv -----
// One storage cell of the queue row: holds the entry at a fixed position from the front.
// Depends on dq_pkg for the value and control types.
module dq_cell #(
    parameter int unsigned DEPTH = 64,
    parameter int unsigned INDEX = 0
) (
    input  logic                       i_clk,
    input  dq_pkg::t_cell_ctrl         i_ctrl,
    input  logic [$clog2(DEPTH+1)-1:0] i_count,
    input  dq_pkg::t_value             i_left,
    input  dq_pkg::t_value             i_right,
    input  dq_pkg::t_value             i_head,
    output dq_pkg::t_value             o_data,
    output dq_pkg::t_value             o_tail
);

    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] POS      = CNT_W'(INDEX);
    localparam logic [CNT_W-1:0] POS_NEXT = CNT_W'(INDEX + 1);

    dq_pkg::t_value r_data;
    logic           is_tail;

    assign is_tail = (i_count == POS_NEXT);
    assign o_data  = r_data;
    assign o_tail  = is_tail ? r_data : '0;

    always_ff @(posedge i_clk) begin
        unique case (i_ctrl.op)
            dq_pkg::CELL_HOLD: begin
                r_data <= r_data;
            end
            // The tail cell takes the old head, so a left shift doubles as a rotation.
            dq_pkg::CELL_SHL: begin
                r_data <= is_tail ? i_head : i_right;
            end
            dq_pkg::CELL_SHR: begin
                r_data <= i_left;
            end
            dq_pkg::CELL_WRITE: begin
                if (i_count == POS) begin
                    r_data <= i_ctrl.inject;
                end
            end
            default: begin
                r_data <= r_data;
            end
        endcase
    end

endmodule

// ----- sv/double_ended_queue.sv -----
// Double-ended queue of signed 32-bit values built from a row of shifting cells.
// Depends on dq_pkg and dq_cell.
//
// Input channel: i_in_valid / o_in_ready with i_req_type and i_value_in.
// Output channel: o_out_valid / i_out_ready with o_value_out, o_has_value,
// o_status and o_last_of_run. Each beat on the output is one result.
// Pushes and pops: the result sits in the output register in the cycle after
// the request beat, and a new request is taken every cycle as long as that
// register is empty or being drained in the same cycle.
// A listing of N entries holds the block for N result beats, one a cycle while
// the receiver takes them, rotating the cell row one place per beat; after the
// last beat the row is back in its original order and requests are taken again.
// Request codes 6 and 7 are taken and produce nothing.
// When the receiver stalls, the output register holds its beat and no further
// request is taken until it drains; nothing is lost.
// Reset empties the queue and clears the output valid flag; the cell contents
// are left as they are and are never read before being written.
module double_ended_queue #(
    parameter int unsigned DEPTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [2:0]  i_req_type,
    input  logic signed [31:0] i_value_in,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic signed [31:0] o_value_out,
    output logic        o_has_value,
    output logic [1:0]  o_status,
    output logic        o_last_of_run
);

    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0] ONE        = CNT_W'(1);

    dq_pkg::t_state     r_state, n_state;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [CNT_W-1:0]   r_remaining, n_remaining;
    logic               r_list_rev, n_list_rev;

    logic               r_out_valid;
    dq_pkg::t_value     r_value_out;
    logic               r_has_value;
    dq_pkg::t_status    r_status;
    logic               r_last;

    logic               out_free;
    logic               in_fire;
    logic               emit;
    dq_pkg::t_value     e_value;
    logic               e_has;
    dq_pkg::t_status    e_status;
    logic               e_last;
    dq_pkg::t_cell_ctrl ctrl;

    dq_pkg::t_value     cell_data [DEPTH];
    dq_pkg::t_value     cell_tail [DEPTH];
    dq_pkg::t_value     head_value;
    dq_pkg::t_value     tail_value;

    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == dq_pkg::ST_IDLE) && out_free;
    assign in_fire    = i_in_valid && o_in_ready;

    assign o_out_valid   = r_out_valid;
    assign o_value_out   = r_value_out;
    assign o_has_value   = r_has_value;
    assign o_status      = r_status;
    assign o_last_of_run = r_last;

    // Cell row: position 0 is the front of the queue.
    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        dq_pkg::t_value left_in;
        dq_pkg::t_value right_in;

        if (k == 0) begin : g_first
            assign left_in = ctrl.inject;
        end else begin : g_mid_l
            assign left_in = cell_data[k-1];
        end

        if (k == DEPTH - 1) begin : g_last
            assign right_in = cell_data[0];
        end else begin : g_mid_r
            assign right_in = cell_data[k+1];
        end

        dq_cell #(
            .DEPTH (DEPTH),
            .INDEX (k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctrl  (ctrl),
            .i_count (r_count),
            .i_left  (left_in),
            .i_right (right_in),
            .i_head  (cell_data[0]),
            .o_data  (cell_data[k]),
            .o_tail  (cell_tail[k])
        );
    end

    assign head_value = cell_data[0];

    // Only the cell at position count-1 contributes, so an OR collects the tail.
    always_comb begin
        tail_value = '0;
        for (int k = 0; k < DEPTH; k++) begin
            tail_value = tail_value | cell_tail[k];
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            dq_pkg::ST_IDLE: begin
                if (in_fire && r_count != '0 &&
                    (dq_pkg::t_req'(i_req_type) == dq_pkg::REQ_LIST_FWD ||
                     dq_pkg::t_req'(i_req_type) == dq_pkg::REQ_LIST_REV)) begin
                    n_state = dq_pkg::ST_LIST;
                end
            end
            dq_pkg::ST_LIST: begin
                if (out_free && r_remaining == ONE) begin
                    n_state = dq_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = dq_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath control and result beat.
    always_comb begin
        ctrl.op     = dq_pkg::CELL_HOLD;
        ctrl.inject = i_value_in;
        n_count     = r_count;
        n_remaining = r_remaining;
        n_list_rev  = r_list_rev;
        emit        = 1'b0;
        e_value     = '0;
        e_has       = 1'b0;
        e_status    = dq_pkg::STATUS_OK;
        e_last      = 1'b1;
        unique case (r_state)
            dq_pkg::ST_IDLE: begin
                if (in_fire) begin
                    unique case (dq_pkg::t_req'(i_req_type))
                        dq_pkg::REQ_PUSH_BACK, dq_pkg::REQ_PUSH_FRONT: begin
                            emit = 1'b1;
                            if (r_count == FULL_COUNT) begin
                                e_status = dq_pkg::STATUS_FULL;
                            end else begin
                                ctrl.op = (dq_pkg::t_req'(i_req_type) ==
                                           dq_pkg::REQ_PUSH_BACK) ?
                                          dq_pkg::CELL_WRITE : dq_pkg::CELL_SHR;
                                n_count = r_count + ONE;
                            end
                        end
                        dq_pkg::REQ_POP_BACK: begin
                            emit = 1'b1;
                            if (r_count == '0) begin
                                e_status = dq_pkg::STATUS_EMPTY;
                            end else begin
                                e_value = tail_value;
                                e_has   = 1'b1;
                                n_count = r_count - ONE;
                            end
                        end
                        dq_pkg::REQ_POP_FRONT: begin
                            emit = 1'b1;
                            if (r_count == '0) begin
                                e_status = dq_pkg::STATUS_EMPTY;
                            end else begin
                                e_value = head_value;
                                e_has   = 1'b1;
                                ctrl.op = dq_pkg::CELL_SHL;
                                n_count = r_count - ONE;
                            end
                        end
                        dq_pkg::REQ_LIST_FWD, dq_pkg::REQ_LIST_REV: begin
                            if (r_count == '0) begin
                                emit     = 1'b1;
                                e_status = dq_pkg::STATUS_EMPTY;
                            end else begin
                                n_remaining = r_count;
                                n_list_rev  = (dq_pkg::t_req'(i_req_type) ==
                                               dq_pkg::REQ_LIST_REV);
                            end
                        end
                        default: begin
                            emit = 1'b0;
                        end
                    endcase
                end
            end
            dq_pkg::ST_LIST: begin
                if (out_free) begin
                    // Emit the end being read and rotate the row one place towards it.
                    emit        = 1'b1;
                    e_has       = 1'b1;
                    e_value     = r_list_rev ? tail_value : head_value;
                    e_last      = (r_remaining == ONE);
                    ctrl.op     = r_list_rev ? dq_pkg::CELL_SHR : dq_pkg::CELL_SHL;
                    ctrl.inject = tail_value;
                    n_remaining = r_remaining - ONE;
                end
            end
            default: begin
                emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= dq_pkg::ST_IDLE;
            r_count     <= '0;
            r_remaining <= '0;
            r_list_rev  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_remaining <= n_remaining;
            r_list_rev  <= n_list_rev;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_value_out <= e_value;
            r_has_value <= e_has;
            r_status    <= e_status;
            r_last      <= e_last;
        end
    end

endmodule

// ----- verif/double_ended_queue_check.sv -----
// Self-checking monitor for the double-ended queue: predicts every result beat and compares.
// Depends on dq_pkg. It is instantiated beside the block by double_ended_queue_test.
module double_ended_queue_check #(
    parameter int unsigned DEPTH = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  logic [2:0]         i_req_type,
    input  logic signed [31:0] i_value_in,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic signed [31:0] i_value_out,
    input  logic               i_has_value,
    input  logic [1:0]         i_status,
    input  logic               i_last_of_run,
    output int                 o_fail_count,
    output int                 o_pending_count,
    output int                 o_request_count,
    output int                 o_beat_count,
    output int                 o_full_count,
    output int                 o_empty_count
);

    typedef struct {
        dq_pkg::t_value  value;
        logic            has_value;
        dq_pkg::t_status status;
        logic            last;
    } t_result_beat;

    // Front of the queue is element 0.
    dq_pkg::t_value stored_entries[$];
    t_result_beat   awaited_results[$];
    t_result_beat   want;

    int fail_count    = 0;
    int request_count = 0;
    int beat_count    = 0;
    int full_count    = 0;
    int empty_count   = 0;

    task automatic await_result(dq_pkg::t_value value, logic has_value,
                                dq_pkg::t_status status, logic last);
        t_result_beat beat;
        beat.value     = value;
        beat.has_value = has_value;
        beat.status    = status;
        beat.last      = last;
        if (status == dq_pkg::STATUS_FULL) full_count++;
        if (status == dq_pkg::STATUS_EMPTY) empty_count++;
        awaited_results.push_back(beat);
    endtask

    task automatic apply_request(logic [2:0] req, dq_pkg::t_value value);
        int n;
        n = stored_entries.size();
        case (req)
            dq_pkg::REQ_PUSH_BACK, dq_pkg::REQ_PUSH_FRONT: begin
                if (n >= DEPTH) begin
                    await_result('0, 1'b0, dq_pkg::STATUS_FULL, 1'b1);
                end else begin
                    if (req == dq_pkg::REQ_PUSH_BACK) stored_entries.push_back(value);
                    else stored_entries.push_front(value);
                    await_result('0, 1'b0, dq_pkg::STATUS_OK, 1'b1);
                end
            end
            dq_pkg::REQ_POP_BACK, dq_pkg::REQ_POP_FRONT: begin
                if (n == 0) begin
                    await_result('0, 1'b0, dq_pkg::STATUS_EMPTY, 1'b1);
                end else if (req == dq_pkg::REQ_POP_BACK) begin
                    await_result(stored_entries.pop_back(), 1'b1, dq_pkg::STATUS_OK, 1'b1);
                end else begin
                    await_result(stored_entries.pop_front(), 1'b1, dq_pkg::STATUS_OK, 1'b1);
                end
            end
            dq_pkg::REQ_LIST_FWD, dq_pkg::REQ_LIST_REV: begin
                if (n == 0) begin
                    await_result('0, 1'b0, dq_pkg::STATUS_EMPTY, 1'b1);
                end else begin
                    for (int i = 0; i < n; i++) begin
                        await_result((req == dq_pkg::REQ_LIST_FWD) ? stored_entries[i]
                                                                  : stored_entries[n-1-i],
                                     1'b1, dq_pkg::STATUS_OK, (i == n - 1));
                    end
                end
            end
            default: ; // The two spare codes are swallowed without a result.
        endcase
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            stored_entries.delete();
            awaited_results.delete();
        end else begin
            if (i_in_valid && i_in_ready) begin
                request_count++;
                apply_request(i_req_type, i_value_in);
            end
            if (i_out_valid && i_out_ready) begin
                beat_count++;
                if (awaited_results.size() == 0) begin
                    $error("result beat with no request waiting: value_out %0d status %0d",
                           i_value_out, i_status);
                    fail_count++;
                end else begin
                    want = awaited_results.pop_front();
                    if (i_value_out !== want.value) begin
                        $error("value_out: expected %0d, got %0d", want.value, i_value_out);
                        fail_count++;
                    end
                    if (i_has_value !== want.has_value) begin
                        $error("has_value: expected %0d, got %0d", want.has_value, i_has_value);
                        fail_count++;
                    end
                    if (i_status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, i_status);
                        fail_count++;
                    end
                    if (i_last_of_run !== want.last) begin
                        $error("last_of_run: expected %0d, got %0d", want.last, i_last_of_run);
                        fail_count++;
                    end
                end
            end
        end
        // Outputs move with the clock so that the top always reads settled values.
        o_fail_count    <= fail_count;
        o_pending_count <= awaited_results.size();
        o_request_count <= request_count;
        o_beat_count    <= beat_count;
        o_full_count    <= full_count;
        o_empty_count   <= empty_count;
    end

endmodule

// ----- verif/double_ended_queue_test.sv -----
// Top of the double-ended queue testbench: clock, reset, request and result stimulus, verdict.
// Depends on dq_pkg, double_ended_queue and double_ended_queue_check.
module double_ended_queue_test;

    localparam int unsigned DEPTH       = 64;
    localparam int          PHASE_COUNT = 10;
    localparam int          PHASE_LEN   = 40;
    localparam int          MAX_CYCLES  = 600000;
    localparam int          TAIL_CYCLES = 8;

    localparam logic [2:0] REQ_SPARE_LO = 3'd6;
    localparam logic [2:0] REQ_SPARE_HI = 3'd7;

    typedef enum {MIX_FILL, MIX_DRAIN, MIX_BALANCED} t_mix;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    logic [2:0]         i_req_type;
    dq_pkg::t_value     i_value_in;
    logic               o_out_valid;
    logic               i_out_ready;
    logic signed [31:0] o_value_out;
    logic               o_has_value;
    logic [1:0]         o_status;
    logic               o_last_of_run;

    int fail_count;
    int pending_count;
    int request_count;
    int beat_count;
    int full_count;
    int empty_count;
    int cycle_count = 0;

    // When set, neither side inserts idle cycles.
    bit calm = 1'b0;

    double_ended_queue #(
        .DEPTH(DEPTH)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_req_type    (i_req_type),
        .i_value_in    (i_value_in),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_value_out   (o_value_out),
        .o_has_value   (o_has_value),
        .o_status      (o_status),
        .o_last_of_run (o_last_of_run)
    );

    double_ended_queue_check #(
        .DEPTH(DEPTH)
    ) u_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_in_ready      (o_in_ready),
        .i_req_type      (i_req_type),
        .i_value_in      (i_value_in),
        .i_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .i_value_out     (o_value_out),
        .i_has_value     (o_has_value),
        .i_status        (o_status),
        .i_last_of_run   (o_last_of_run),
        .o_fail_count    (fail_count),
        .o_pending_count (pending_count),
        .o_request_count (request_count),
        .o_beat_count    (beat_count),
        .o_full_count    (full_count),
        .o_empty_count   (empty_count)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= MAX_CYCLES) begin
            $display("Run stopped after %0d cycles with %0d results outstanding.",
                     cycle_count, pending_count);
            $display("FAILURE");
            $finish;
        end
    end

    // Valid is only lowered when a gap is drawn, so it never drops and rises in one step.
    task automatic send_request(logic [2:0] req, dq_pkg::t_value value);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_req_type <= req;
        i_value_in <= value;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    function automatic dq_pkg::t_value draw_value();
        case ($urandom_range(0, 11))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2:       return '0;
            3:       return '1;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [2:0] draw_request(t_mix mix);
        int roll;
        int push_lim;
        int pop_lim;
        roll = $urandom_range(0, 99);
        case (mix)
            MIX_FILL:  begin push_lim = 88; pop_lim = 93; end
            MIX_DRAIN: begin push_lim = 7;  pop_lim = 92; end
            default:   begin push_lim = 45; pop_lim = 85; end
        endcase
        if (roll < push_lim)
            return $urandom_range(0, 1) ? dq_pkg::REQ_PUSH_FRONT : dq_pkg::REQ_PUSH_BACK;
        if (roll < pop_lim)
            return $urandom_range(0, 1) ? dq_pkg::REQ_POP_FRONT : dq_pkg::REQ_POP_BACK;
        if (roll < 98)
            return $urandom_range(0, 1) ? dq_pkg::REQ_LIST_REV : dq_pkg::REQ_LIST_FWD;
        return $urandom_range(0, 1) ? REQ_SPARE_HI : REQ_SPARE_LO;
    endfunction

    initial begin
        int   stall;
        i_out_ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            stall = calm ? 0 : $urandom_range(0, 3);
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    initial begin
        logic [2:0] req;
        int         counted;
        t_mix       mix;
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_req_type <= dq_pkg::REQ_PUSH_BACK;
        i_value_in <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Every pop and listing request against an empty queue.
        send_request(dq_pkg::REQ_POP_BACK, '0);
        send_request(dq_pkg::REQ_POP_FRONT, '1);
        send_request(dq_pkg::REQ_LIST_FWD, '0);
        send_request(dq_pkg::REQ_LIST_REV, '0);
        // Popping the only entry from either end must leave the queue empty.
        send_request(dq_pkg::REQ_PUSH_BACK, 32'sh7FFF_FFFF);
        send_request(dq_pkg::REQ_POP_FRONT, '0);
        send_request(dq_pkg::REQ_POP_BACK, '0);
        send_request(dq_pkg::REQ_PUSH_FRONT, 32'sh8000_0000);
        send_request(dq_pkg::REQ_POP_BACK, '0);
        // Build a short queue from both ends, list it both ways, send both spare codes and drain it past empty.
        send_request(dq_pkg::REQ_PUSH_BACK, '1);
        send_request(dq_pkg::REQ_PUSH_FRONT, '0);
        send_request(dq_pkg::REQ_PUSH_BACK, 32'sd1);
        send_request(dq_pkg::REQ_PUSH_FRONT, 32'sh8000_0000);
        send_request(dq_pkg::REQ_PUSH_BACK, 32'sh7FFF_FFFF);
        send_request(dq_pkg::REQ_LIST_FWD, '0);
        send_request(dq_pkg::REQ_LIST_REV, '1);
        send_request(REQ_SPARE_LO, 32'sh5A5A_A5A5);
        send_request(REQ_SPARE_HI, 32'shA5A5_5A5A);
        send_request(dq_pkg::REQ_POP_FRONT, '0);
        send_request(dq_pkg::REQ_POP_BACK, '0);
        send_request(dq_pkg::REQ_POP_FRONT, '0);
        send_request(dq_pkg::REQ_POP_BACK, '0);
        send_request(dq_pkg::REQ_POP_FRONT, '0);
        send_request(dq_pkg::REQ_POP_FRONT, '0);

        // Two filling phases in a row push the queue past full, two draining ones past empty.
        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            case (phase % 5)
                0, 1:    mix = MIX_FILL;
                3, 4:    mix = MIX_DRAIN;
                default: mix = MIX_BALANCED;
            endcase
            calm    = (phase % 3 == 2);
            counted = 0;
            while (counted < PHASE_LEN) begin
                req = draw_request(mix);
                send_request(req, draw_value());
                if (req != REQ_SPARE_LO && req != REQ_SPARE_HI) counted++;
            end
        end
        calm = 1'b0;
        i_in_valid <= 1'b0;

        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Sent %0d requests and checked %0d result beats in %0d cycles.",
                 request_count, beat_count, cycle_count);
        $display("Pushes refused as full: %0d; empty-queue results: %0d.",
                 full_count, empty_count);
        if (fail_count == 0 && pending_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
